>>> src/fgas_pkg.sv
// ----------------------------------------------------------------------------
// fgas_pkg
// Shared constants, types and codes of the keypoint grid search block.
// ----------------------------------------------------------------------------
package fgas_pkg;

  localparam int GRID_COLS    = 64;
  localparam int GRID_ROWS    = 48;
  localparam int MAX_FEATURES = 1024;
  localparam int MAX_MATCHES  = 64;

  localparam int NCELLS  = GRID_COLS * GRID_ROWS;
  localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CELL_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int FEAT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int COUNT_W = $clog2(MAX_FEATURES + 1);
  localparam int MATCH_W = $clog2(MAX_MATCHES + 1);

  localparam int ACT_W      = 2;
  localparam int POS_W      = 17;
  localparam int LVL_W      = 3;
  localparam int RAD_W      = 16;
  localparam int MAXL_W     = 4;
  localparam int SCALE_W    = 16;
  localparam int IDX_W      = 10;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int DIFF_W = POS_W + 2;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;
  localparam int FRAC_W = 20;
  localparam int CIDX_W = PROD_W - FRAC_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(6554);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_SCALE_X  = 2'd2,
    CFG_SCALE_Y  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [SCALE_W-1:0]      cell_scale_x;
    logic [SCALE_W-1:0]      cell_scale_y;
  } cfg_t;

  typedef struct packed {
    action_t                  kind;
    logic                     hit;
    logic [COL_W-1:0]         col_lo;
    logic [COL_W-1:0]         col_hi;
    logic [ROW_W-1:0]         row_lo;
    logic [ROW_W-1:0]         row_hi;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [LVL_W-1:0]         level;
    logic [RAD_W-1:0]         radius;
    logic [LVL_W-1:0]         min_level;
    logic signed [MAXL_W-1:0] max_level;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [FEAT_W-1:0] head;
    logic [FEAT_W-1:0] tail;
  } cell_ent_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [LVL_W-1:0]        level;
  } feat_ent_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_CLR,
    S_INS,
    S_LINK,
    S_QRY,
    S_QCELL,
    S_QHEAD,
    S_QENT,
    S_QFIN,
    S_EMIT
  } back_state_t;

endpackage

>>> src/fgas_in_if.sv
// ----------------------------------------------------------------------------
// fgas_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface fgas_in_if;
  import fgas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [LVL_W-1:0]         level;
  logic [RAD_W-1:0]         radius;
  logic [LVL_W-1:0]         min_level;
  logic signed [MAXL_W-1:0] max_level;

  modport source (output valid, action, pos_x, pos_y, level, radius, min_level,
                  max_level, input ready);
  modport sink (input valid, action, pos_x, pos_y, level, radius, min_level,
                max_level, output ready);
endinterface

>>> src/fgas_out_if.sv
// ----------------------------------------------------------------------------
// fgas_out_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface fgas_out_if;
  import fgas_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  feature_index;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, feature_index, status, last, input ready);
  modport sink (input valid, feature_index, status, last, output ready);
endinterface

>>> src/fgas_cfg_if.sv
// ----------------------------------------------------------------------------
// fgas_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fgas_cfg_if;
  import fgas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/fgas_front.sv
// ----------------------------------------------------------------------------
// fgas_front
// Accepts input words, scales the offsets to grid units and builds commands.
// ----------------------------------------------------------------------------
module fgas_front
  import fgas_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  fgas_in_if.sink in_ch,
  output logic    push_valid,
  input  logic    push_ready,
  output cmd_t    push_cmd
);

  localparam logic signed [CIDX_W-1:0] COLS_S = CIDX_W'(GRID_COLS);
  localparam logic signed [CIDX_W-1:0] ROWS_S = CIDX_W'(GRID_ROWS);
  localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(64'd1 << (FRAC_W - 1));
  localparam logic [PROD_W-1:0] MASK_Q = PROD_W'((64'd1 << FRAC_W) - 64'd1);

  logic                     a_valid_r;
  action_t                  a_act_r;
  logic signed [POS_W-1:0]  a_pos_x_r;
  logic signed [POS_W-1:0]  a_pos_y_r;
  logic [LVL_W-1:0]         a_level_r;
  logic [RAD_W-1:0]         a_radius_r;
  logic [LVL_W-1:0]         a_min_r;
  logic signed [MAXL_W-1:0] a_max_r;
  logic signed [DIFF_W-1:0] a_dxl_r;
  logic signed [DIFF_W-1:0] a_dxh_r;
  logic signed [DIFF_W-1:0] a_dyl_r;
  logic signed [DIFF_W-1:0] a_dyh_r;

  logic                     b_valid_r;
  action_t                  b_act_r;
  logic signed [POS_W-1:0]  b_pos_x_r;
  logic signed [POS_W-1:0]  b_pos_y_r;
  logic [LVL_W-1:0]         b_level_r;
  logic [RAD_W-1:0]         b_radius_r;
  logic [LVL_W-1:0]         b_min_r;
  logic signed [MAXL_W-1:0] b_max_r;
  logic signed [PROD_W-1:0] b_pxl_r;
  logic signed [PROD_W-1:0] b_pxh_r;
  logic signed [PROD_W-1:0] b_pyl_r;
  logic signed [PROD_W-1:0] b_pyh_r;

  logic                     b_done;
  logic                     b_free;
  logic                     a_adv;
  logic                     in_acc;
  logic [DIFF_W-1:0]        rad_ext;
  logic signed [PROD_W-1:0] scale_x;
  logic signed [PROD_W-1:0] scale_y;

  logic signed [CIDX_W-1:0] lo_x;
  logic signed [CIDX_W-1:0] hi_x;
  logic signed [CIDX_W-1:0] lo_y;
  logic signed [CIDX_W-1:0] hi_y;
  logic                     win_ok;
  logic [CIDX_W-1:0]        q_x;
  logic [CIDX_W-1:0]        q_y;
  logic                     ins_ok;

  function automatic logic signed [CIDX_W-1:0] floor_cell(
    input logic signed [PROD_W-1:0] p);
    floor_cell = p[PROD_W-1:FRAC_W];
  endfunction

  function automatic logic signed [CIDX_W-1:0] ceil_cell(
    input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + MASK_Q;
    ceil_cell = s[PROD_W-1:FRAC_W];
  endfunction

  function automatic logic [CIDX_W-1:0] round_mag(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] s;
    m = p[PROD_W-1] ? -p : p;
    s = m + HALF_Q;
    round_mag = s[PROD_W-1:FRAC_W];
  endfunction

  assign b_done       = b_valid_r && ((b_act_r == ACT_NOP) || push_ready);
  assign b_free       = !b_valid_r || b_done;
  assign a_adv        = a_valid_r && b_free;
  assign in_ch.ready  = !a_valid_r || b_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign rad_ext      = (action_t'(in_ch.action) == ACT_QUERY) ?
                        DIFF_W'(in_ch.radius) : '0;
  assign scale_x      = PROD_W'($signed({1'b0, cfg.cell_scale_x}));
  assign scale_y      = PROD_W'($signed({1'b0, cfg.cell_scale_y}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_act_r    <= action_t'(in_ch.action);
      a_pos_x_r  <= in_ch.pos_x;
      a_pos_y_r  <= in_ch.pos_y;
      a_level_r  <= in_ch.level;
      a_radius_r <= in_ch.radius;
      a_min_r    <= in_ch.min_level;
      a_max_r    <= in_ch.max_level;
      a_dxl_r    <= DIFF_W'(in_ch.pos_x) - DIFF_W'(cfg.origin_x) - rad_ext;
      a_dxh_r    <= DIFF_W'(in_ch.pos_x) - DIFF_W'(cfg.origin_x) + rad_ext;
      a_dyl_r    <= DIFF_W'(in_ch.pos_y) - DIFF_W'(cfg.origin_y) - rad_ext;
      a_dyh_r    <= DIFF_W'(in_ch.pos_y) - DIFF_W'(cfg.origin_y) + rad_ext;
    end
    if (a_adv) begin
      b_act_r    <= a_act_r;
      b_pos_x_r  <= a_pos_x_r;
      b_pos_y_r  <= a_pos_y_r;
      b_level_r  <= a_level_r;
      b_radius_r <= a_radius_r;
      b_min_r    <= a_min_r;
      b_max_r    <= a_max_r;
      b_pxl_r    <= PROD_W'(a_dxl_r) * scale_x;
      b_pxh_r    <= PROD_W'(a_dxh_r) * scale_x;
      b_pyl_r    <= PROD_W'(a_dyl_r) * scale_y;
      b_pyh_r    <= PROD_W'(a_dyh_r) * scale_y;
    end
  end

  always_comb begin
    lo_x   = floor_cell(b_pxl_r);
    hi_x   = ceil_cell(b_pxh_r);
    lo_y   = floor_cell(b_pyl_r);
    hi_y   = ceil_cell(b_pyh_r);
    win_ok = (lo_x < COLS_S) && (hi_x >= 0) && (lo_y < ROWS_S) && (hi_y >= 0);
    q_x    = round_mag(b_pxl_r);
    q_y    = round_mag(b_pyl_r);
    ins_ok = (q_x < CIDX_W'(GRID_COLS)) && (!b_pxl_r[PROD_W-1] || (q_x == '0)) &&
             (q_y < CIDX_W'(GRID_ROWS)) && (!b_pyl_r[PROD_W-1] || (q_y == '0));

    push_cmd.kind      = b_act_r;
    push_cmd.pos_x     = b_pos_x_r;
    push_cmd.pos_y     = b_pos_y_r;
    push_cmd.level     = b_level_r;
    push_cmd.radius    = b_radius_r;
    push_cmd.min_level = b_min_r;
    push_cmd.max_level = b_max_r;
    if (b_act_r == ACT_INSERT) begin
      push_cmd.hit    = ins_ok;
      push_cmd.col_lo = q_x[COL_W-1:0];
      push_cmd.row_lo = q_y[ROW_W-1:0];
      push_cmd.col_hi = q_x[COL_W-1:0];
      push_cmd.row_hi = q_y[ROW_W-1:0];
    end else begin
      push_cmd.hit    = win_ok;
      push_cmd.col_lo = lo_x[CIDX_W-1] ? '0 : lo_x[COL_W-1:0];
      push_cmd.row_lo = lo_y[CIDX_W-1] ? '0 : lo_y[ROW_W-1:0];
      push_cmd.col_hi = (hi_x > COLS_S - 1) ? COL_W'(GRID_COLS - 1) : hi_x[COL_W-1:0];
      push_cmd.row_hi = (hi_y > ROWS_S - 1) ? ROW_W'(GRID_ROWS - 1) : hi_y[ROW_W-1:0];
    end
  end

  assign push_valid = b_valid_r && (b_act_r != ACT_NOP);

endmodule

>>> src/fgas_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fgas_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module fgas_cmd_fifo
  import fgas_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r < QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/fgas_back.sv
// ----------------------------------------------------------------------------
// fgas_back
// Executes commands against the keypoint table and the cell lists.
// ----------------------------------------------------------------------------
module fgas_back
  import fgas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd_in,
  fgas_out_if.source  out_ch
);

  cell_ent_t cell_mem [NCELLS];
  feat_ent_t feat_mem [MAX_FEATURES];
  logic [FEAT_W-1:0] next_mem [MAX_FEATURES];

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [CELL_W-1:0]  sweep_r, sweep_nxt;
  logic [FEAT_W-1:0]  idx_r, idx_nxt;
  logic [CELL_W-1:0]  caddr_r, caddr_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [FEAT_W-1:0]  ent_r, ent_nxt;
  logic [FEAT_W-1:0]  tail_r, tail_nxt;
  logic [MATCH_W-1:0] n_r, n_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [FEAT_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic               more_r, more_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  status_t            res_stat_r, res_stat_nxt;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  status_t            out_stat_r;
  logic               out_last_r;

  logic              out_load;
  logic [IDX_W-1:0]  out_idx_d;
  status_t           out_stat_d;
  logic              out_last_d;

  logic              cell_we, cell_re;
  logic [CELL_W-1:0] cell_waddr, cell_raddr;
  cell_ent_t         cell_wdata, cell_q;
  logic              feat_we, feat_re;
  logic [FEAT_W-1:0] feat_waddr, feat_raddr;
  feat_ent_t         feat_wdata, feat_q;
  logic              next_we;
  logic [FEAT_W-1:0] next_waddr;
  logic [FEAT_W-1:0] next_wdata, next_q;

  logic                    out_free;
  logic                    full;
  logic signed [POS_W:0]   dx, dy;
  logic [POS_W:0]          adx, ady;
  logic                    lvl_ok;
  logic                    hit;
  logic                    cap;
  logic                    ent_last;
  logic                    row_end;
  logic                    cell_end;
  logic [CELL_W-1:0]       ins_addr;
  logic [CELL_W-1:0]       scan_addr;

  function automatic logic [CELL_W-1:0] cell_of(input logic [COL_W-1:0] c,
                                                input logic [ROW_W-1:0] r);
    cell_of = CELL_W'(c) * CELL_W'(GRID_ROWS) + CELL_W'(r);
  endfunction

  assign out_free  = !out_valid_r || out_ch.ready;
  assign full      = count_r >= COUNT_W'(MAX_FEATURES);
  assign dx        = (POS_W + 1)'(feat_q.x) - (POS_W + 1)'(cmd_r.pos_x);
  assign dy        = (POS_W + 1)'(feat_q.y) - (POS_W + 1)'(cmd_r.pos_y);
  assign adx       = dx[POS_W] ? -dx : dx;
  assign ady       = dy[POS_W] ? -dy : dy;
  assign lvl_ok    = (feat_q.level >= cmd_r.min_level) &&
                     (cmd_r.max_level[MAXL_W-1] ||
                      (feat_q.level <= cmd_r.max_level[LVL_W-1:0]));
  assign hit       = lvl_ok && (adx < (POS_W + 1)'(cmd_r.radius)) &&
                     (ady < (POS_W + 1)'(cmd_r.radius));
  assign cap       = n_r >= MATCH_W'(MAX_MATCHES);
  assign ent_last  = ent_r == tail_r;
  assign row_end   = row_r == cmd_r.row_hi;
  assign cell_end  = row_end && (col_r == cmd_r.col_hi);
  assign ins_addr  = cell_of(cmd_r.col_lo, cmd_r.row_lo);
  assign scan_addr = cell_of(col_r, row_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_r == CELL_W'(NCELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_in.kind)
            ACT_CLEAR:  state_nxt = S_CLR;
            ACT_INSERT: state_nxt = S_INS;
            ACT_QUERY:  state_nxt = S_QRY;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        if (out_free) begin
          state_nxt = S_SWEEP;
        end
      end
      S_INS: begin
        if (!full && cmd_r.hit) begin
          state_nxt = S_LINK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_LINK: state_nxt = S_EMIT;
      S_QRY:  state_nxt = cmd_r.hit ? S_QCELL : S_EMIT;
      S_QCELL: state_nxt = S_QHEAD;
      S_QHEAD: begin
        if (cell_q.valid) begin
          state_nxt = S_QENT;
        end else begin
          state_nxt = cell_end ? S_QFIN : S_QCELL;
        end
      end
      S_QENT: begin
        priority if (hit && cap) begin
          state_nxt = S_QFIN;
        end else if (hit && pend_v_r && !out_free) begin
          state_nxt = S_QENT;
        end else if (ent_last) begin
          state_nxt = cell_end ? S_QFIN : S_QCELL;
        end else begin
          state_nxt = S_QENT;
        end
      end
      S_QFIN, S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    sweep_nxt    = sweep_r;
    idx_nxt      = idx_r;
    caddr_nxt    = caddr_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    ent_nxt      = ent_r;
    tail_nxt     = tail_r;
    n_nxt        = n_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    more_nxt     = more_r;
    res_idx_nxt  = res_idx_r;
    res_stat_nxt = res_stat_r;
    cmd_ready    = 1'b0;
    out_load     = 1'b0;
    out_idx_d    = '0;
    out_stat_d   = ST_OK;
    out_last_d   = 1'b1;
    cell_we      = 1'b0;
    cell_waddr   = caddr_r;
    cell_wdata   = '0;
    cell_re      = 1'b0;
    cell_raddr   = scan_addr;
    feat_we      = 1'b0;
    feat_waddr   = count_r[FEAT_W-1:0];
    feat_wdata   = '{x: cmd_r.pos_x, y: cmd_r.pos_y, level: cmd_r.level};
    feat_re      = 1'b0;
    feat_raddr   = next_q;
    next_we      = 1'b0;
    next_waddr   = cell_q.tail;
    next_wdata   = idx_r;

    unique case (state_r)
      S_SWEEP: begin
        cell_we    = 1'b1;
        cell_waddr = sweep_r;
        sweep_nxt  = sweep_r + 1'b1;
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd_in;
        end
      end
      S_CLR: begin
        if (out_free) begin
          out_load  = 1'b1;
          count_nxt = '0;
          sweep_nxt = '0;
        end
      end
      S_INS: begin
        if (full) begin
          res_idx_nxt  = '0;
          res_stat_nxt = ST_FULL;
        end else begin
          feat_we      = 1'b1;
          idx_nxt      = count_r[FEAT_W-1:0];
          count_nxt    = count_r + 1'b1;
          caddr_nxt    = ins_addr;
          cell_re      = cmd_r.hit;
          cell_raddr   = ins_addr;
          res_idx_nxt  = IDX_W'(count_r[FEAT_W-1:0]);
          res_stat_nxt = ST_NONE;
        end
      end
      S_LINK: begin
        next_we      = cell_q.valid;
        cell_we      = 1'b1;
        cell_wdata   = '{valid: 1'b1, head: cell_q.valid ? cell_q.head : idx_r, tail: idx_r};
        res_idx_nxt  = IDX_W'(idx_r);
        res_stat_nxt = ST_OK;
      end
      S_QRY: begin
        col_nxt      = cmd_r.col_lo;
        row_nxt      = cmd_r.row_lo;
        n_nxt        = '0;
        pend_v_nxt   = 1'b0;
        more_nxt     = 1'b0;
        res_idx_nxt  = '0;
        res_stat_nxt = ST_NONE;
      end
      S_QCELL: begin
        cell_re = 1'b1;
      end
      S_QHEAD: begin
        if (cell_q.valid) begin
          ent_nxt    = cell_q.head;
          tail_nxt   = cell_q.tail;
          feat_re    = 1'b1;
          feat_raddr = cell_q.head;
        end else if (!cell_end) begin
          if (row_end) begin
            row_nxt = cmd_r.row_lo;
            col_nxt = col_r + 1'b1;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      S_QENT: begin
        priority if (hit && cap) begin
          more_nxt = 1'b1;
        end else if (hit && pend_v_r && !out_free) begin
          more_nxt = more_r;
        end else begin
          if (hit) begin
            out_load     = pend_v_r;
            out_idx_d    = IDX_W'(pend_idx_r);
            out_last_d   = 1'b0;
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = ent_r;
            n_nxt        = n_r + 1'b1;
          end
          if (!ent_last) begin
            ent_nxt    = next_q;
            feat_re    = 1'b1;
            feat_raddr = next_q;
          end else if (!cell_end) begin
            if (row_end) begin
              row_nxt = cmd_r.row_lo;
              col_nxt = col_r + 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
        end
      end
      S_QFIN: begin
        out_load   = out_free;
        out_idx_d  = pend_v_r ? IDX_W'(pend_idx_r) : '0;
        out_stat_d = !pend_v_r ? ST_NONE : (more_r ? ST_TRUNC : ST_OK);
      end
      S_EMIT: begin
        out_load   = out_free;
        out_idx_d  = res_idx_r;
        out_stat_d = res_stat_r;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      more_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sweep_r  <= sweep_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      more_r   <= more_nxt;
      n_r      <= n_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    caddr_r    <= caddr_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    ent_r      <= ent_nxt;
    tail_r     <= tail_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_idx_r  <= out_idx_d;
      out_stat_r <= out_stat_d;
      out_last_r <= out_last_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feat_waddr] <= feat_wdata;
    end
    if (feat_re) begin
      feat_q <= feat_mem[feat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (feat_re) begin
      next_q <= next_mem[feat_raddr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.feature_index = out_idx_r;
  assign out_ch.status        = out_stat_r;
  assign out_ch.last          = out_last_r;

endmodule

>>> src/feature_grid_area_search_core.sv
// ----------------------------------------------------------------------------
// feature_grid_area_search_core
// Uniform grid index of image keypoints with an area search.
// ----------------------------------------------------------------------------
// After reset the block first sweeps all NCELLS (3072) cells of the cell
// table, one cell per cycle, before it executes commands; a clear word repeats
// that sweep after its single result. Words are taken into a two-stage front
// that scales offsets into grid units and then into a two-entry command queue,
// so up to four words other than no-ops are taken while the back is busy. In
// the back an insert steps through dispatch, table write and cell read, list
// link and result, and skips the link when the table is full or the keypoint
// lies off the grid. A query reads the head of each window cell in turn and
// then each keypoint filed in it; each match is one result word, with the last
// result flagged. Configuration writes are always ready and are registered.
// ----------------------------------------------------------------------------
module feature_grid_area_search_core
  import fgas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fgas_in_if.sink     in_ch,
  fgas_out_if.source  out_ch,
  fgas_cfg_if.sink    cfg_ch
);

  cfg_t cfg_r;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.cell_scale_x <= SCALE_RESET;
      cfg_r.cell_scale_y <= SCALE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_ORIGIN_X: cfg_r.origin_x     <= cfg_ch.data;
        CFG_ORIGIN_Y: cfg_r.origin_y     <= cfg_ch.data;
        CFG_SCALE_X:  cfg_r.cell_scale_x <= cfg_ch.data[SCALE_W-1:0];
        CFG_SCALE_Y:  cfg_r.cell_scale_y <= cfg_ch.data[SCALE_W-1:0];
        default:      cfg_r.origin_x     <= cfg_r.origin_x;
      endcase
    end
  end

  fgas_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fgas_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fgas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd_in    (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule

>>> test/tb_feature_grid_area_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feature_grid_area_search_core
// Self-checking bench for the keypoint grid search block: a scoreboard keeps
// its own keypoint table and cell lists, predicts the words of every accepted
// command and checks each result word in order, over several grid settings.
// ----------------------------------------------------------------------------
module tb_feature_grid_area_search_core;
  import fgas_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    status_t          st;
    logic             last;
  } grid_hit_t;

  localparam longint ONE20  = longint'(1) << 20;
  localparam longint HALF20 = longint'(1) << 19;
  localparam int     LIMIT_CYCLES = 2000000;
  localparam int     SETTLE_CYCLES = 3300;
  localparam int     CLUSTER_WORDS = 70;

  class grid_scoreboard;
    longint      org_x, org_y;
    int unsigned scl_x, scl_y;
    int unsigned count;
    longint      kp_x[MAX_FEATURES];
    longint      kp_y[MAX_FEATURES];
    int          kp_lvl[MAX_FEATURES];
    int unsigned link[MAX_FEATURES];
    int unsigned head[NCELLS];
    int unsigned tail[NCELLS];
    bit          filled[NCELLS];
    grid_hit_t   expected_hits[$];
    int          errors;

    function new();
      org_x = 0;
      org_y = 0;
      scl_x = 6554;
      scl_y = 6554;
      count = 0;
      errors = 0;
      foreach (filled[i]) filled[i] = 0;
    endfunction

    function longint floor20(longint p);
      if (p >= 0) return p / ONE20;
      return -((-p + ONE20 - 1) / ONE20);
    endfunction

    function longint ceil20(longint p);
      return -floor20(-p);
    endfunction

    function longint round20(longint p);
      if (p >= 0) return (p + HALF20) / ONE20;
      return -((-p + HALF20) / ONE20);
    endfunction

    function void push_hit(int unsigned idx, status_t st, bit last);
      grid_hit_t h;
      h.idx = idx[IDX_W-1:0];
      h.st = st;
      h.last = last;
      expected_hits.insert(expected_hits.size(), h);
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        CFG_ORIGIN_X: org_x = longint'($signed(d));
        CFG_ORIGIN_Y: org_y = longint'($signed(d));
        CFG_SCALE_X:  scl_x = d[SCALE_W-1:0];
        CFG_SCALE_Y:  scl_y = d[SCALE_W-1:0];
      endcase
    endfunction

    function void file_keypoint(longint px, longint py, int lvl);
      int unsigned idx;
      longint cx, cy;
      int unsigned c;
      idx = count;
      if (idx >= MAX_FEATURES) begin
        push_hit(0, ST_FULL, 1);
        return;
      end
      kp_x[idx] = px;
      kp_y[idx] = py;
      kp_lvl[idx] = lvl;
      count = idx + 1;
      cx = round20((px - org_x) * longint'(scl_x));
      cy = round20((py - org_y) * longint'(scl_y));
      if (cx < 0 || cx >= GRID_COLS || cy < 0 || cy >= GRID_ROWS) begin
        push_hit(idx, ST_NONE, 1);
        return;
      end
      c = cx * GRID_ROWS + cy;
      if (filled[c]) begin
        link[tail[c]] = idx;
      end else begin
        head[c] = idx;
        filled[c] = 1;
      end
      tail[c] = idx;
      push_hit(idx, ST_OK, 1);
    endfunction

    function void search_area(longint x, longint y, longint r, int minl, int maxl);
      longint lox, hix, loy, hiy, dx, dy;
      bit filt, more, ok;
      int unsigned c, e;
      grid_hit_t found[$];
      grid_hit_t h;
      filt = (minl > 0) || (maxl >= 0);
      more = 0;
      lox = floor20((x - org_x - r) * longint'(scl_x));
      if (lox < 0) lox = 0;
      hix = ceil20((x - org_x + r) * longint'(scl_x));
      if (hix > GRID_COLS - 1) hix = GRID_COLS - 1;
      loy = floor20((y - org_y - r) * longint'(scl_y));
      if (loy < 0) loy = 0;
      hiy = ceil20((y - org_y + r) * longint'(scl_y));
      if (hiy > GRID_ROWS - 1) hiy = GRID_ROWS - 1;
      if (lox < GRID_COLS && hix >= 0 && loy < GRID_ROWS && hiy >= 0) begin
        for (longint ix = lox; ix <= hix && !more; ix++) begin
          for (longint iy = loy; iy <= hiy && !more; iy++) begin
            c = ix * GRID_ROWS + iy;
            if (!filled[c]) continue;
            e = head[c];
            for (int s = 0; s < MAX_FEATURES; s++) begin
              ok = 1;
              if (filt) begin
                if (kp_lvl[e] < minl) ok = 0;
                if (maxl >= 0 && kp_lvl[e] > maxl) ok = 0;
              end
              if (ok) begin
                dx = kp_x[e] - x;
                dy = kp_y[e] - y;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx < r && dy < r) begin
                  if (found.size() >= MAX_MATCHES) begin
                    more = 1;
                    break;
                  end
                  h.idx = e[IDX_W-1:0];
                  h.st = ST_OK;
                  h.last = 0;
                  found.insert(found.size(), h);
                end
              end
              if (e == tail[c]) break;
              e = link[e];
            end
          end
        end
      end
      if (found.size() == 0) begin
        push_hit(0, ST_NONE, 1);
        return;
      end
      found[found.size()-1].last = 1;
      if (more) found[found.size()-1].st = ST_TRUNC;
      foreach (found[i]) expected_hits.insert(expected_hits.size(), found[i]);
    endfunction

    function void note_word(action_t a, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic [LVL_W-1:0] lv,
                            logic [RAD_W-1:0] r, logic [LVL_W-1:0] minl,
                            logic signed [MAXL_W-1:0] maxl);
      case (a)
        ACT_CLEAR: begin
          count = 0;
          foreach (filled[i]) filled[i] = 0;
          push_hit(0, ST_OK, 1);
        end
        ACT_INSERT: file_keypoint(longint'(x), longint'(y), int'(lv));
        ACT_QUERY:  search_area(longint'(x), longint'(y), longint'(r), int'(minl),
                                int'(maxl));
        default: ;
      endcase
    endfunction

    function void check_word(logic [IDX_W-1:0] idx, logic [STAT_W-1:0] st, logic last);
      grid_hit_t h;
      if (expected_hits.size() == 0) begin
        $error("result word with none expected: feature_index %0d status %0d last %0d",
               idx, st, last);
        errors++;
        return;
      end
      h = expected_hits.pop_front();
      if (idx !== h.idx) begin
        $error("feature_index expected %0d actual %0d", h.idx, idx);
        errors++;
      end
      if (st !== h.st) begin
        $error("status expected %0d actual %0d", h.st, st);
        errors++;
      end
      if (last !== h.last) begin
        $error("last expected %0d actual %0d", h.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  fgas_in_if  in_ch ();
  fgas_out_if out_ch ();
  fgas_cfg_if cfg_ch ();

  feature_grid_area_search_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  grid_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  longint cur_org_x = 0, cur_org_y = 0;
  int unsigned cur_scl_x = 6554, cur_scl_y = 6554;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(action_t'(in_ch.action), in_ch.pos_x, in_ch.pos_y, in_ch.level,
                     in_ch.radius, in_ch.min_level, in_ch.max_level);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.feature_index, out_ch.status, out_ch.last);
    end
  end

  initial begin
    out_ch.ready <= 0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_word(action_t a, longint x, longint y, int lv, int r,
                           int minl, int maxl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid     <= 1;
    in_ch.action    <= a;
    in_ch.pos_x     <= x[POS_W-1:0];
    in_ch.pos_y     <= y[POS_W-1:0];
    in_ch.level     <= lv[LVL_W-1:0];
    in_ch.radius    <= r[RAD_W-1:0];
    in_ch.min_level <= minl[LVL_W-1:0];
    in_ch.max_level <= maxl[MAXL_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, longint d);
    cfg_ch.valid <= 1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_grid(longint ox, longint oy, int unsigned sx, int unsigned sy);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    cur_org_x = ox;
    cur_org_y = oy;
    cur_scl_x = sx;
    cur_scl_y = sy;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic longint grid_span(int unsigned s, int cells);
    longint sp;
    if (s == 0) return 65535;
    sp = (longint'(cells) << 20) / s;
    return (sp > 65535) ? 65535 : sp;
  endfunction

  function automatic longint pick_pos(longint org, int unsigned s, int cells);
    if ($urandom_range(0, 7) == 0) return longint'($urandom_range(0, 131071)) - 65536;
    return org + $urandom_range(0, grid_span(s, cells));
  endfunction

  task automatic random_words(int n);
    int k, r, minl, maxl;
    longint x, y;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      x = pick_pos(cur_org_x, cur_scl_x, GRID_COLS);
      y = pick_pos(cur_org_y, cur_scl_y, GRID_ROWS);
      if (k < 2) begin
        send_word(ACT_CLEAR, x, y, 0, 0, 0, -1);
      end else if (k < 4) begin
        send_word(ACT_NOP, x, y, $urandom_range(0, 7), $urandom_range(0, 65535), 0, 0);
        i--;
      end else if (k < 55) begin
        send_word(ACT_INSERT, x, y, $urandom_range(0, 7), $urandom_range(0, 65535),
                  $urandom_range(0, 7), $urandom_range(0, 15));
      end else begin
        case ($urandom_range(0, 19))
          0: r = 0;
          1: r = $urandom_range(0, 65535);
          default: r = $urandom_range(1, grid_span(cur_scl_x, GRID_COLS) / 16 + 1);
        endcase
        if ($urandom_range(0, 1)) begin
          minl = 0;
          maxl = -1;
        end else begin
          minl = $urandom_range(0, 7);
          maxl = $urandom_range(0, 15);
        end
        send_word(ACT_QUERY, x, y, $urandom_range(0, 7), r, minl, maxl);
      end
    end
  endtask

  initial begin
    rst_n        <= 0;
    in_ch.valid  <= 0;
    in_ch.action <= ACT_NOP;
    in_ch.pos_x  <= 0;
    in_ch.pos_y  <= 0;
    in_ch.level  <= 0;
    in_ch.radius <= 0;
    in_ch.min_level <= 0;
    in_ch.max_level <= 0;
    cfg_ch.valid <= 0;
    cfg_ch.index <= CFG_ORIGIN_X;
    cfg_ch.data  <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Field extremes, every command and the corner cases at the reset grid.
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, -1);
    send_word(ACT_QUERY, 1600, 1600, 0, 800, 0, -1);
    send_word(ACT_INSERT, -65536, -65536, 0, 0, 0, 0);
    send_word(ACT_INSERT, 65535, 65535, 7, 65535, 7, 7);
    send_word(ACT_INSERT, 0, 0, 7, 0, 0, 0);
    send_word(ACT_INSERT, 0, 0, 0, 0, 0, 0);
    send_word(ACT_INSERT, 10239, 7679, 3, 0, 0, 0);
    send_word(ACT_INSERT, 80, 80, 5, 0, 0, 0);
    send_word(ACT_INSERT, 90, 70, 2, 0, 0, 0);
    send_word(ACT_NOP, 1234, 4321, 4, 100, 3, 3);
    send_word(ACT_QUERY, 80, 80, 0, 0, 0, -1);
    send_word(ACT_QUERY, 80, 80, 0, 65535, 0, -1);
    send_word(ACT_QUERY, 80, 80, 0, 400, 3, 5);
    send_word(ACT_QUERY, 80, 80, 0, 400, 0, 2);
    send_word(ACT_QUERY, 80, 80, 0, 400, 6, -8);
    send_word(ACT_QUERY, 10239, 7679, 0, 16, 0, -1);
    send_word(ACT_QUERY, -65536, -65536, 0, 16, 0, -1);
    send_word(ACT_QUERY, 65535, 65535, 0, 16, 7, 7);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, -1);
    send_word(ACT_QUERY, 80, 80, 0, 400, 0, -1);
    random_words(50);
    drain();

    set_grid(-65536, -4000, 65535, 30000);
    random_words(30);
    drain();

    set_grid(65535, 0, 0, 1);
    random_words(20);
    drain();

    set_grid(0, 0, 6554, 6554);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, -1);
    for (int i = 0; i < CLUSTER_WORDS; i++) begin
      if (i == 10) hold_req = 1;
      send_word(ACT_INSERT, 1600 + $urandom_range(0, 64) - 32,
                1600 + $urandom_range(0, 64) - 32, $urandom_range(0, 7), 0, 0, 0);
    end
    send_word(ACT_QUERY, 1600, 1600, 0, 64, 0, -1);
    send_word(ACT_QUERY, 1600, 1600, 0, 64, 2, 4);
    send_word(ACT_QUERY, 1600, 1600, 0, 64, 7, -1);
    send_word(ACT_QUERY, 1610, 1590, 0, 8, 0, 0);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, -1);
    calm = 1;
    random_words(40);
    drain();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> feature_grid_area_search_core.f
src/fgas_pkg.sv
src/fgas_in_if.sv
src/fgas_out_if.sv
src/fgas_cfg_if.sv
src/fgas_front.sv
src/fgas_cmd_fifo.sv
src/fgas_back.sv
src/feature_grid_area_search_core.sv
test/tb_feature_grid_area_search_core.sv
